// File: src/vpae_pkg.sv
package vpae_pkg;

  localparam int CoordWidth = 12;
  localparam int ByteWidth  = 7;
  localparam int MaxBytes   = 6;
  localparam int CountWidth = $clog2(MaxBytes + 1);

  // Scaling to terminal units: (v + 2048) * 780 / 1024.
  localparam int ScaleNum   = 780;
  localparam int ScaleWidth = 10;
  localparam int ScaleShift = 10;
  localparam int ProdWidth  = CoordWidth + ScaleWidth;

  typedef enum logic [1:0] {
    OP_DRAW   = 2'd0,
    OP_MOVE   = 2'd1,
    OP_FORGET = 2'd2,
    OP_UNUSED = 2'd3
  } op_t;

  localparam logic [ByteWidth-1:0] TagHigh  = 7'o040;
  localparam logic [ByteWidth-1:0] TagLowY  = 7'o140;
  localparam logic [ByteWidth-1:0] TagLowX  = 7'o100;
  localparam logic [ByteWidth-1:0] DarkByte = 7'o035;

  typedef struct packed {
    logic [1:0]                   operation;
    logic signed [CoordWidth-1:0] coord_x;
    logic signed [CoordWidth-1:0] coord_y;
  } cmd_t;

  typedef struct packed {
    logic [ByteWidth-1:0] out_byte;
    logic                 last_byte;
  } plot_t;

  typedef struct packed {
    logic [4:0] high_y;
    logic [4:0] high_x;
    logic [4:0] low_y;
    logic [3:0] extra_bits;
    logic       valid;
  } history_t;

  typedef struct packed {
    logic [MaxBytes-1:0][ByteWidth-1:0] bytes;
    logic [CountWidth-1:0]              count;
  } byte_list_t;

endpackage

// File: src/vpae_list_builder.sv
module vpae_list_builder (
  input  vpae_pkg::cmd_t      cmd,
  input  vpae_pkg::history_t  history,
  output vpae_pkg::byte_list_t list,
  output vpae_pkg::history_t  history_next
);
  import vpae_pkg::*;

  logic [CoordWidth-1:0] bias_x, bias_y;
  logic [ProdWidth-1:0]  prod_x, prod_y;
  logic [CoordWidth-1:0] term_x, term_y;
  logic [4:0]            high_x, high_y, low_x, low_y;
  logic [3:0]            extra;
  logic                  is_point;
  logic                  send_hy, send_hx, send_ex, send_ly;
  logic [MaxBytes-1:0][ByteWidth-1:0] bytes;
  logic [CountWidth-1:0] n;

  // Adding 2048 to a 12-bit two's complement value flips its sign bit.
  assign bias_x = {~cmd.coord_x[CoordWidth-1], cmd.coord_x[CoordWidth-2:0]};
  assign bias_y = {~cmd.coord_y[CoordWidth-1], cmd.coord_y[CoordWidth-2:0]};
  assign prod_x = ProdWidth'(bias_x) * ProdWidth'(ScaleNum);
  assign prod_y = ProdWidth'(bias_y) * ProdWidth'(ScaleNum);
  assign term_x = prod_x[ScaleShift +: CoordWidth];
  assign term_y = prod_y[ScaleShift +: CoordWidth];

  assign high_x = term_x[11:7];
  assign high_y = term_y[11:7];
  assign low_x  = term_x[6:2];
  assign low_y  = term_y[6:2];
  assign extra  = {term_y[1:0], term_x[1:0]};

  assign is_point = (cmd.operation == OP_DRAW) || (cmd.operation == OP_MOVE);

  assign send_hy = !history.valid || (high_y != history.high_y);
  assign send_hx = !history.valid || (high_x != history.high_x);
  assign send_ex = !history.valid || (extra != history.extra_bits);
  assign send_ly = !history.valid || (low_y != history.low_y);

  always_comb begin
    bytes = '0;
    n     = '0;
    if (cmd.operation == OP_MOVE) begin
      bytes[n] = DarkByte;
      n        = n + 1'b1;
    end
    if (send_hy) begin
      bytes[n] = TagHigh | {2'b00, high_y};
      n        = n + 1'b1;
    end
    if (send_hx) begin
      if (send_ex) begin
        bytes[n] = TagLowY | {3'b000, extra};
        n        = n + 1'b1;
      end
      bytes[n] = TagLowY | {2'b00, low_y};
      n        = n + 1'b1;
      bytes[n] = TagHigh | {2'b00, high_x};
      n        = n + 1'b1;
    end else if (send_ex) begin
      bytes[n] = TagLowY | {3'b000, extra};
      n        = n + 1'b1;
      bytes[n] = TagLowY | {2'b00, low_y};
      n        = n + 1'b1;
    end else if (send_ly) begin
      bytes[n] = TagLowY | {2'b00, low_y};
      n        = n + 1'b1;
    end
    bytes[n] = TagLowX | {2'b00, low_x};
    n        = n + 1'b1;

    list.bytes = bytes;
    list.count = is_point ? n : '0;
  end

  // After any point the remembered parts are exactly that point's parts.
  always_comb begin
    history_next = history;
    case (cmd.operation)
      OP_DRAW, OP_MOVE: begin
        history_next.high_y     = high_y;
        history_next.high_x     = high_x;
        history_next.low_y      = low_y;
        history_next.extra_bits = extra;
        history_next.valid      = 1'b1;
      end
      OP_FORGET: begin
        history_next = '0;
      end
      default: begin
        history_next = history;
      end
    endcase
  end

endmodule

// File: src/vector_plot_address_encoder.sv
// Plot-address encoder for a vector terminal with 12-bit addressing.
// The cmd channel takes one word per command: an operation (draw, move or
// forget) and a signed point. The plot channel returns the address bytes of
// that command one word at a time; last_byte marks the final byte of each
// command. A draw gives one to five bytes, a move one more (the dark-vector
// byte first), and a forget or the unused code gives no bytes at all.
// Both channels use valid and stall; a word moves on an edge where valid is
// high and stall is low.
// The first byte of a command passes through the shift buffer and the
// output register before it appears on the plot port.
// The byte list is built in the cycle of acceptance and held in a shift
// buffer, and an output register drains it one byte per cycle while the plot
// channel does not stall. The next command is taken in the cycle the last
// byte of the current one moves into the output register.
// A stall on the plot channel holds the output register and the buffer; the
// cmd channel then stalls once the buffer holds bytes still to be sent.
// Reset empties the buffer and the output register and clears the
// remembered bytes, so the first point after reset sends its full address.
module vector_plot_address_encoder (
  input  logic            clk,
  input  logic            rst,
  input  logic            cmd_valid,
  output logic            cmd_stall,
  input  vpae_pkg::cmd_t  cmd,
  output logic            plot_valid,
  input  logic            plot_stall,
  output vpae_pkg::plot_t plot
);
  import vpae_pkg::*;

  history_t   history;
  history_t   history_next;
  byte_list_t list;

  // Bytes of the command being sent; entry zero goes out next.
  logic [MaxBytes-1:0][ByteWidth-1:0] pending;
  logic [MaxBytes-1:0][ByteWidth-1:0] pending_next;
  logic [CountWidth-1:0]              left;
  logic [CountWidth-1:0]              left_next;

  logic load_out;
  logic buf_free;
  logic accept;

  vpae_list_builder u_list (
    .cmd          (cmd),
    .history      (history),
    .list         (list),
    .history_next (history_next)
  );

  // The output register takes a byte whenever it is empty or being emptied.
  assign load_out  = (!plot_valid || !plot_stall) && (left != '0);
  // The buffer is free when empty or when its last byte leaves this cycle.
  assign buf_free  = (left == '0) || ((left == CountWidth'(1)) && load_out);
  assign cmd_stall = !buf_free;
  assign accept    = cmd_valid && buf_free;

  always_comb begin
    pending_next = pending;
    left_next    = left;
    if (load_out) begin
      for (int i = 0; i < MaxBytes - 1; i++) begin
        pending_next[i] = pending[i+1];
      end
      left_next = left - 1'b1;
    end
    if (accept && (list.count != '0)) begin
      pending_next = list.bytes;
      left_next    = list.count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      history    <= '0;
      left       <= '0;
      plot_valid <= 1'b0;
    end else begin
      if (accept) begin
        history <= history_next;
      end
      left <= left_next;
      if (load_out) begin
        plot_valid <= 1'b1;
      end else if (!plot_stall) begin
        plot_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pending <= pending_next;
    if (load_out) begin
      plot.out_byte  <= pending[0];
      plot.last_byte <= (left == CountWidth'(1));
    end
  end

endmodule

// File: test/vector_plot_address_encoder_tb.sv
module vector_plot_address_encoder_tb;
  import vpae_pkg::*;

  logic  clk        = 1'b0;
  logic  rst        = 1'b1;
  logic  cmd_valid  = 1'b0;
  logic  cmd_stall;
  cmd_t  cmd        = '0;
  logic  plot_valid;
  logic  plot_stall = 1'b0;
  plot_t plot;

  // Commands waiting to be sent, and the plot bytes the encoder owes us,
  // oldest first.
  cmd_t  pending_cmds[$];
  plot_t expected_bytes[$];

  // Our own copy of what the terminal was last told.
  history_t plot_history = '0;

  int fail_count = 0;

  // Sender burst and gap bookkeeping.
  int burst_left = 0;
  int gap_left   = 0;

  // Receiver stall pattern: a mode is held for a while, then a new one is drawn.
  int stall_mode  = 0;
  int stall_hold  = 0;
  int stall_phase = 0;

  // The last point queued, so that random points can land close to it and
  // exercise the byte suppression paths.
  int last_x = 0;
  int last_y = 0;

  vector_plot_address_encoder u_top (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .plot_valid(plot_valid),
    .plot_stall(plot_stall),
    .plot      (plot)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Map a signed view coordinate to terminal units. Adding 2048 to a 12-bit
  // two's complement value is the same as flipping its sign bit; the result is
  // then scaled by 780/1024 with truncation, giving 0..3119.
  function automatic logic [11:0] to_terminal(input logic [CoordWidth-1:0] v);
    logic [CoordWidth-1:0] biased;
    logic [31:0]           prod;
    biased = {~v[CoordWidth-1], v[CoordWidth-2:0]};
    prod   = biased * ScaleNum;
    return prod[ScaleShift +: 12];
  endfunction

  // Work out the plot bytes one command should produce and update the
  // remembered address parts the same way the terminal would see them.
  function automatic void encode_command(input cmd_t c);
    logic [11:0]          tx;
    logic [11:0]          ty;
    logic [4:0]           hix;
    logic [4:0]           hiy;
    logic [4:0]           lox;
    logic [4:0]           loy;
    logic [3:0]           extra;
    logic [ByteWidth-1:0] stream[$];
    if (c.operation == OP_FORGET) begin
      plot_history = '0;
      return;
    end
    if (c.operation == OP_UNUSED) begin
      return;
    end
    tx    = to_terminal(c.coord_x);
    ty    = to_terminal(c.coord_y);
    hix   = tx[11:7];
    hiy   = ty[11:7];
    lox   = tx[6:2];
    loy   = ty[6:2];
    // The two extra bits of x sit low, the two of y just above them.
    extra = {ty[1:0], tx[1:0]};

    if (c.operation == OP_MOVE) begin
      stream.push_back(DarkByte);
    end
    if (!plot_history.valid || hiy != plot_history.high_y) begin
      stream.push_back({2'b00, hiy} | TagHigh);
      plot_history.high_y = hiy;
    end
    if (!plot_history.valid || hix != plot_history.high_x) begin
      // A new high x forces low y and high x out; the extra byte only goes
      // when it changed.
      if (!plot_history.valid || extra != plot_history.extra_bits) begin
        stream.push_back({3'b000, extra} | TagLowY);
        plot_history.extra_bits = extra;
      end
      stream.push_back({2'b00, loy} | TagLowY);
      stream.push_back({2'b00, hix} | TagHigh);
      plot_history.high_x = hix;
      plot_history.low_y  = loy;
    end else if (extra != plot_history.extra_bits) begin
      stream.push_back({3'b000, extra} | TagLowY);
      stream.push_back({2'b00, loy} | TagLowY);
      plot_history.extra_bits = extra;
      plot_history.low_y      = loy;
    end else if (loy != plot_history.low_y) begin
      stream.push_back({2'b00, loy} | TagLowY);
      plot_history.low_y = loy;
    end
    // The low x byte closes every point.
    stream.push_back({2'b00, lox} | TagLowX);
    plot_history.valid = 1'b1;

    foreach (stream[i]) begin
      expected_bytes.push_back('{out_byte: stream[i], last_byte: (i == stream.size() - 1)});
    end
  endfunction

  function automatic int clamp_view(input int v);
    if (v < -2048) return -2048;
    if (v > 2047) return 2047;
    return v;
  endfunction

  task automatic queue_command(input op_t op, input int x, input int y);
    cmd_t c;
    c.operation = op;
    c.coord_x   = x[CoordWidth-1:0];
    c.coord_y   = y[CoordWidth-1:0];
    pending_cmds.push_back(c);
    last_x = x;
    last_y = y;
  endtask

  // Driver. A word stays on the port until it is taken; the next one (or a
  // gap) is chosen only once the port is free. Bursts of random length are
  // broken up by random gaps, and many gaps are zero so that long runs of
  // back-to-back words also occur.
  always @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (!cmd_valid || !cmd_stall) begin
      if (gap_left > 0) begin
        gap_left--;
        cmd_valid <= 1'b0;
      end else if (pending_cmds.size() > 0) begin
        cmd       <= pending_cmds.pop_front();
        cmd_valid <= 1'b1;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 20);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
        end else begin
          burst_left--;
        end
      end else begin
        cmd_valid <= 1'b0;
      end
    end
  end

  // Receiver stall pattern. Each mode is held for a random stretch: no
  // stalls at all, coin flips, mostly stalled, or a fixed two-in-five rhythm.
  always @(posedge clk) begin
    if (rst) begin
      plot_stall <= 1'b0;
    end else begin
      if (stall_hold == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_hold = $urandom_range(10, 60);
      end else begin
        stall_hold--;
      end
      stall_phase = (stall_phase + 1) % 5;
      case (stall_mode)
        0:       plot_stall <= 1'b0;
        1:       plot_stall <= ($urandom_range(0, 1) == 1);
        2:       plot_stall <= ($urandom_range(0, 7) != 0);
        default: plot_stall <= (stall_phase < 2);
      endcase
    end
  end

  // Monitor. Values are sampled as they stood before this edge. An accepted
  // command is predicted first; its bytes pass the buffer and the output
  // register first, so the order of the steps below never matters at an edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (cmd_valid && !cmd_stall) begin
        encode_command(cmd);
      end
      if (plot_valid && !plot_stall) begin
        if (expected_bytes.size() == 0) begin
          $error("plot word with none expected: out_byte %0o last_byte %0b",
                 plot.out_byte, plot.last_byte);
          fail_count++;
        end else begin
          plot_t want;
          want = expected_bytes.pop_front();
          if (plot.out_byte !== want.out_byte) begin
            $error("out_byte: expected %0o, got %0o", want.out_byte, plot.out_byte);
            fail_count++;
          end
          if (plot.last_byte !== want.last_byte) begin
            $error("last_byte: expected %0b, got %0b", want.last_byte, plot.last_byte);
            fail_count++;
          end
        end
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    int   pick;
    int   x;
    int   y;
    op_t  op;

    // Directed part. A forget with nothing remembered, then the four corners
    // of the coordinate range and the origin.
    queue_command(OP_FORGET, 0, 0);
    queue_command(OP_DRAW, -2048, -2048);
    queue_command(OP_DRAW, 2047, 2047);
    queue_command(OP_MOVE, -2048, 2047);
    queue_command(OP_DRAW, 2047, -2048);
    queue_command(OP_DRAW, 0, 0);
    // The same point again sends only the low x byte.
    queue_command(OP_DRAW, 0, 0);
    queue_command(OP_MOVE, 0, 0);
    // Small steps in y change the extra bits or the low y part alone.
    queue_command(OP_DRAW, 0, 2);
    queue_command(OP_DRAW, 0, 8);
    queue_command(OP_DRAW, 0, 40);
    // Small and large steps in x: extra bits, then a new high x.
    queue_command(OP_DRAW, 2, 40);
    queue_command(OP_DRAW, 600, 40);
    // A new high y with everything else kept.
    queue_command(OP_DRAW, 600, 1000);
    // The unused code leaves the history alone, so the next point is short.
    queue_command(OP_UNUSED, -1, -1);
    queue_command(OP_DRAW, 600, 1000);
    // After a forget the full address goes out again even for the same point.
    queue_command(OP_FORGET, 2047, 2047);
    queue_command(OP_DRAW, 600, 1000);
    queue_command(OP_MOVE, -1, -1);
    queue_command(OP_DRAW, 1, 1);
    queue_command(OP_UNUSED, 2047, -2048);

    // Random part. Mostly draws and moves; points are often near the last
    // one so that every suppression path comes up, with full-range and
    // extreme points mixed in.
    for (int i = 0; i < 160; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 5) op = OP_FORGET;
      else if (pick < 10) op = OP_UNUSED;
      else if (pick < 35) op = OP_MOVE;
      else op = OP_DRAW;
      case ($urandom_range(0, 5))
        0, 1: begin
          x = int'($urandom_range(0, 4095)) - 2048;
          y = int'($urandom_range(0, 4095)) - 2048;
        end
        2, 3: begin
          x = clamp_view(last_x + int'($urandom_range(0, 16)) - 8);
          y = clamp_view(last_y + int'($urandom_range(0, 16)) - 8);
        end
        4: begin
          x = clamp_view(last_x + int'($urandom_range(0, 400)) - 200);
          y = clamp_view(last_y + int'($urandom_range(0, 400)) - 200);
        end
        default: begin
          pick = $urandom_range(0, 3);
          x    = (pick == 0) ? -2048 : (pick == 1) ? 2047 : (pick == 2) ? 0 : -1;
          pick = $urandom_range(0, 3);
          y    = (pick == 0) ? -2048 : (pick == 1) ? 2047 : (pick == 2) ? 0 : -1;
        end
      endcase
      queue_command(op, x, y);
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Wait until every command has been taken and every byte has come back,
    // then keep watching for any stray word before ending the run.
    @(negedge clk);
    while (pending_cmds.size() > 0 || cmd_valid || expected_bytes.size() > 0) begin
      @(negedge clk);
    end
    repeat (20) @(negedge clk);

    if (expected_bytes.size() > 0) begin
      $error("%0d plot words never arrived", expected_bytes.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("vector_plot_address_encoder test passed");
    end else begin
      $display("vector_plot_address_encoder test failed");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #2000000;
    $display("vector_plot_address_encoder test failed");
    $finish;
  end

endmodule

// File: files.f
src/vpae_pkg.sv
src/vpae_list_builder.sv
src/vector_plot_address_encoder.sv
test/vector_plot_address_encoder_tb.sv
